### rtl/psm_pkg.sv
// ============================================================================
// psm_pkg
// Shared types and constants of the process slot manager: call codes, slot
// states, and the command and status bundles between controller and datapath.
// ============================================================================
package psm_pkg;

    // All ones, the failure code returned to a caller.
    localparam logic [31:0] NEG_ONE = 32'hFFFF_FFFF;

    // System call codes.
    typedef enum logic [2:0] {
        OP_GETPID    = 3'd0,
        OP_FORK      = 3'd1,
        OP_YIELD     = 3'd2,
        OP_EXIT      = 3'd3,
        OP_WAIT      = 3'd4,
        OP_NEWTHREAD = 3'd5,
        OP_KILL      = 3'd6,
        OP_UNKNOWN   = 3'd7
    } psm_op_t;

    // Per-slot state codes.
    typedef enum logic [1:0] {
        SLOT_EMPTY  = 2'd0,
        SLOT_RUN    = 2'd1,
        SLOT_BLOCK  = 2'd2,
        SLOT_ZOMBIE = 2'd3
    } psm_slot_t;

    // Slot address sources for table writes.
    typedef enum logic [1:0] {
        A_CUR    = 2'd0,
        A_TGT    = 2'd1,
        A_WAITER = 2'd2,
        A_CHK    = 2'd3
    } psm_asel_t;

    // Sources of the caller's return value.
    typedef enum logic [2:0] {
        RET_CUR  = 3'd0,
        RET_NEG1 = 3'd1,
        RET_ZERO = 3'd2,
        RET_EXIT = 3'd3,
        RET_CHK  = 3'd4
    } psm_ret_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      latch;
        logic      set_halt;
        logic      ret_en;
        psm_ret_t  ret_sel;
        logic      probe;
        logic      probe_cur;
        logic      st_we;
        psm_asel_t st_asel;
        psm_slot_t st_wval;
        logic      ex_we;
        psm_asel_t ex_asel;
        logic      ex_arg;
        logic      lk_we;
        psm_asel_t lk_asel;
        logic      lk_set;
        logic      wake_load;
        logic      scan_start;
        logic      scan_alloc;
        logic      scan_step;
        logic      sched_take;
        logic      set_idle;
        logic      out_load;
    } psm_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic      halt_now;
        psm_op_t   op;
        logic      arg_ok;
        psm_slot_t tgt_state;
        logic      link_valid;
        logic      scan_hit;
        logic      scan_miss;
        logic      out_free;
    } psm_sts_t;

endpackage

### rtl/psm_ram.sv
// ============================================================================
// psm_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module psm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; a read of the written address
    // returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/psm_controller.sv
// ============================================================================
// psm_controller
// Sequencer of the process slot manager. It steps each system call through
// decode, target check, waiter release, slot scan and result hand-off.
// ============================================================================
module psm_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  psm_pkg::psm_sts_t  sts,
    output psm_pkg::psm_ctl_t  ctl
);

    import psm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_DECODE  = 7'b0000010,
        S_CHECK   = 7'b0000100,
        S_RELEASE = 7'b0001000,
        S_FREE    = 7'b0010000,
        S_SCAN    = 7'b0100000,
        S_FINISH  = 7'b1000000
    } psm_state_t;

    psm_state_t state_reg;
    psm_state_t state_next;
    logic       is_alloc;

    assign is_alloc  = (sts.op == OP_FORK) || (sts.op == OP_NEWTHREAD);
    assign req_stall = (state_reg != S_IDLE);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                if (sts.halt_now)
                begin
                    ctl.set_halt = 1'b1;
                    state_next   = S_FINISH;
                end
                else
                begin
                    unique case (sts.op)
                        OP_GETPID:
                        begin
                            ctl.ret_en  = 1'b1;
                            ctl.ret_sel = RET_CUR;
                            state_next  = S_FINISH;
                        end
                        OP_FORK, OP_NEWTHREAD:
                        begin
                            ctl.scan_start = 1'b1;
                            ctl.scan_alloc = 1'b1;
                            state_next     = S_SCAN;
                        end
                        OP_YIELD:
                        begin
                            ctl.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                        OP_EXIT:
                        begin
                            // Current slot turns zombie; fetch its waiter link.
                            ctl.st_we     = 1'b1;
                            ctl.st_asel   = A_CUR;
                            ctl.st_wval   = SLOT_ZOMBIE;
                            ctl.ex_we     = 1'b1;
                            ctl.ex_asel   = A_CUR;
                            ctl.ex_arg    = 1'b1;
                            ctl.probe     = 1'b1;
                            ctl.probe_cur = 1'b1;
                            state_next    = S_RELEASE;
                        end
                        OP_WAIT, OP_KILL:
                        begin
                            if (sts.arg_ok)
                            begin
                                ctl.probe  = 1'b1;
                                state_next = S_CHECK;
                            end
                            else
                            begin
                                ctl.ret_en  = 1'b1;
                                ctl.ret_sel = RET_NEG1;
                                if (sts.op == OP_WAIT)
                                begin
                                    ctl.scan_start = 1'b1;
                                    state_next     = S_SCAN;
                                end
                                else
                                begin
                                    state_next = S_FINISH;
                                end
                            end
                        end
                        OP_UNKNOWN:
                        begin
                            ctl.set_halt = 1'b1;
                            state_next   = S_FINISH;
                        end
                    endcase
                end
            end

            S_CHECK:
            begin
                if (sts.tgt_state == SLOT_EMPTY)
                begin
                    ctl.ret_en  = 1'b1;
                    ctl.ret_sel = RET_NEG1;
                    if (sts.op == OP_WAIT)
                    begin
                        ctl.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else if (sts.op == OP_WAIT)
                begin
                    if (sts.tgt_state == SLOT_ZOMBIE)
                    begin
                        // Reap the zombie and hand its status to the caller.
                        ctl.ret_en  = 1'b1;
                        ctl.ret_sel = RET_EXIT;
                        ctl.st_we   = 1'b1;
                        ctl.st_asel = A_TGT;
                        ctl.st_wval = SLOT_EMPTY;
                        ctl.lk_we   = 1'b1;
                        ctl.lk_asel = A_TGT;
                    end
                    else
                    begin
                        // Record the caller as waiter and block it.
                        ctl.lk_we   = 1'b1;
                        ctl.lk_asel = A_TGT;
                        ctl.lk_set  = 1'b1;
                        ctl.st_we   = 1'b1;
                        ctl.st_asel = A_CUR;
                        ctl.st_wval = SLOT_BLOCK;
                    end
                    ctl.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    ctl.ret_en  = 1'b1;
                    ctl.ret_sel = RET_ZERO;
                    if (sts.tgt_state != SLOT_ZOMBIE)
                    begin
                        ctl.st_we   = 1'b1;
                        ctl.st_asel = A_TGT;
                        ctl.st_wval = SLOT_ZOMBIE;
                        ctl.ex_we   = 1'b1;
                        ctl.ex_asel = A_TGT;
                        state_next  = S_RELEASE;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_RELEASE:
            begin
                if (sts.link_valid)
                begin
                    ctl.st_we     = 1'b1;
                    ctl.st_asel   = A_WAITER;
                    ctl.st_wval   = SLOT_RUN;
                    ctl.wake_load = 1'b1;
                    state_next    = S_FREE;
                end
                else if (sts.op == OP_EXIT)
                begin
                    ctl.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_FREE:
            begin
                ctl.st_we   = 1'b1;
                ctl.st_asel = A_TGT;
                ctl.st_wval = SLOT_EMPTY;
                ctl.lk_we   = 1'b1;
                ctl.lk_asel = A_TGT;
                if (sts.op == OP_EXIT)
                begin
                    ctl.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (sts.scan_hit)
                begin
                    if (is_alloc)
                    begin
                        ctl.st_we   = 1'b1;
                        ctl.st_asel = A_CHK;
                        ctl.st_wval = SLOT_RUN;
                        ctl.lk_we   = 1'b1;
                        ctl.lk_asel = A_CHK;
                        ctl.ret_en  = 1'b1;
                        ctl.ret_sel = RET_CHK;
                    end
                    else
                    begin
                        ctl.sched_take = 1'b1;
                    end
                    state_next = S_FINISH;
                end
                else if (sts.scan_miss)
                begin
                    if (is_alloc)
                    begin
                        ctl.ret_en  = 1'b1;
                        ctl.ret_sel = RET_NEG1;
                    end
                    else
                    begin
                        ctl.set_idle = 1'b1;
                    end
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

endmodule

### rtl/psm_datapath.sv
// ============================================================================
// psm_datapath
// Slot tables, current slot, scan counters and result registers of the
// process slot manager. Executes the commands of the controller.
// ============================================================================
module psm_datapath #(
    parameter int NUM_SLOTS = 16,
    localparam int SW = $clog2(NUM_SLOTS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  psm_pkg::psm_ctl_t  ctl,
    output psm_pkg::psm_sts_t  sts,
    input  logic [2:0]         cmd,
    input  logic signed [31:0] argument,
    input  logic               res_stall,
    output logic               res_valid,
    output logic               return_valid,
    output logic signed [31:0] return_value,
    output logic               wake_valid,
    output logic [3:0]         wake_slot,
    output logic signed [31:0] wake_value,
    output logic [3:0]         next_slot,
    output logic               none_runnable,
    output logic               halted
);

    import psm_pkg::*;

    localparam int            CW       = SW + 1;
    localparam logic [31:0]   NSLOT32  = 32'(NUM_SLOTS);
    localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SLOTS - 1);
    localparam logic [SW-1:0] IDX_ONE  = SW'(1);

    // Request and per-call registers.
    psm_op_t            op_reg;
    logic signed [31:0] arg_reg;
    logic [SW-1:0]      tgt_reg;
    logic [31:0]        stat_reg;
    logic               rv_reg;
    logic [31:0]        rval_reg;
    logic               wkv_reg;
    logic [SW-1:0]      wks_reg;
    logic [31:0]        wkval_reg;
    logic               idle_reg;

    // Persistent control state.
    logic [SW-1:0]        cur_reg;
    logic                 halt_reg;
    logic [NUM_SLOTS-1:0] st_vld_reg;
    logic [NUM_SLOTS-1:0] ex_vld_reg;
    logic [NUM_SLOTS-1:0] lk_vld_reg;
    logic                 st_rvld_reg;
    logic                 ex_rvld_reg;
    logic                 lk_rvld_reg;
    logic [SW-1:0]        st_raddr_reg;

    // Scan unit.
    logic [SW-1:0] scan_addr_reg;
    logic [CW-1:0] scan_left_reg;
    logic [SW-1:0] chk_idx_reg;
    logic          chk_vld_reg;
    logic          chk_last_reg;
    logic          scan_alloc_reg;

    // Result register.
    logic          res_valid_reg;
    logic          o_rv_reg;
    logic [31:0]   o_rval_reg;
    logic          o_wkv_reg;
    logic [3:0]    o_wks_reg;
    logic [31:0]   o_wkval_reg;
    logic [3:0]    o_next_reg;
    logic          o_idle_reg;
    logic          o_halt_reg;

    // Memory ports.
    logic [31:0]   arg_u;
    logic [SW-1:0] arg_idx;
    logic          arg_ok;
    logic [SW-1:0] probe_addr;
    logic          scan_rd;
    logic          st_rd_en;
    logic [SW-1:0] st_rd_addr;
    logic [1:0]    st_q;
    logic [31:0]   ex_q;
    logic [SW:0]   lk_q;
    logic [SW-1:0] st_waddr;
    logic [SW-1:0] ex_waddr;
    logic [SW-1:0] lk_waddr;
    logic [31:0]   ex_wdata;
    logic [SW:0]   lk_wdata;
    psm_slot_t     st_val;
    logic [31:0]   ex_val;
    logic          lk_valid;
    logic [SW-1:0] lk_idx;
    psm_slot_t     scan_target;
    logic          scan_match;
    logic          out_free;

    // Next index of a round robin over the slots.
    function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] x);
        logic [SW-1:0] r;
        if (x == LAST_IDX)
        begin
            r = '0;
        end
        else
        begin
            r = x + IDX_ONE;
        end
        return r;
    endfunction

    // Slot address selection for table writes.
    function automatic logic [SW-1:0] pick(input psm_asel_t s,
                                           input logic [SW-1:0] cur,
                                           input logic [SW-1:0] tgt,
                                           input logic [SW-1:0] wtr,
                                           input logic [SW-1:0] chk);
        logic [SW-1:0] r;
        unique case (s)
            A_CUR:    r = cur;
            A_TGT:    r = tgt;
            A_WAITER: r = wtr;
            A_CHK:    r = chk;
        endcase
        return r;
    endfunction

    // Target checks on the argument.
    assign arg_u   = arg_reg;
    assign arg_idx = arg_reg[SW-1:0];
    assign arg_ok  = (arg_u != 32'd0) && (arg_u < NSLOT32) && (arg_idx != cur_reg);

    // Read addresses: a probe looks at one slot, the scan walks the state table.
    assign probe_addr = ctl.probe_cur ? cur_reg : arg_idx;
    assign scan_rd    = ctl.scan_step && (scan_left_reg != '0);
    assign st_rd_en   = ctl.probe || scan_rd;
    assign st_rd_addr = ctl.scan_step ? scan_addr_reg : probe_addr;

    // Write addresses and data.
    assign st_waddr = pick(ctl.st_asel, cur_reg, tgt_reg, lk_idx, chk_idx_reg);
    assign ex_waddr = pick(ctl.ex_asel, cur_reg, tgt_reg, lk_idx, chk_idx_reg);
    assign lk_waddr = pick(ctl.lk_asel, cur_reg, tgt_reg, lk_idx, chk_idx_reg);
    assign ex_wdata = ctl.ex_arg ? arg_reg : NEG_ONE;
    assign lk_wdata = ctl.lk_set ? {1'b1, cur_reg} : '0;

    psm_ram #(.WIDTH(2), .DEPTH(NUM_SLOTS)) u_state_ram (
        .clk     (clk),
        .wr_en   (ctl.st_we),
        .wr_addr (st_waddr),
        .wr_data (ctl.st_wval),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_q)
    );

    psm_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_exit_ram (
        .clk     (clk),
        .wr_en   (ctl.ex_we),
        .wr_addr (ex_waddr),
        .wr_data (ex_wdata),
        .rd_en   (ctl.probe),
        .rd_addr (probe_addr),
        .rd_data (ex_q)
    );

    psm_ram #(.WIDTH(SW + 1), .DEPTH(NUM_SLOTS)) u_link_ram (
        .clk     (clk),
        .wr_en   (ctl.lk_we),
        .wr_addr (lk_waddr),
        .wr_data (lk_wdata),
        .rd_en   (ctl.probe),
        .rd_addr (probe_addr),
        .rd_data (lk_q)
    );

    // Entries never written read as their reset contents.
    always_comb
    begin
        if (st_rvld_reg)
        begin
            st_val = psm_slot_t'(st_q);
        end
        else if (st_raddr_reg == IDX_ONE)
        begin
            st_val = SLOT_RUN;
        end
        else
        begin
            st_val = SLOT_EMPTY;
        end
    end

    assign ex_val   = ex_rvld_reg ? ex_q : '0;
    assign lk_valid = lk_rvld_reg && lk_q[SW];
    assign lk_idx   = lk_q[SW-1:0];

    // Scan compare: allocation looks for an empty slot, scheduling for a runnable one.
    assign scan_target = scan_alloc_reg ? SLOT_EMPTY : SLOT_RUN;
    assign scan_match  = (st_val == scan_target);
    assign out_free    = !res_valid_reg || !res_stall;

    // Status to the controller.
    always_comb
    begin
        sts.halt_now   = halt_reg || (op_reg == OP_UNKNOWN);
        sts.op         = op_reg;
        sts.arg_ok     = arg_ok;
        sts.tgt_state  = st_val;
        sts.link_valid = lk_valid;
        sts.scan_hit   = chk_vld_reg && scan_match;
        sts.scan_miss  = chk_vld_reg && chk_last_reg && !scan_match;
        sts.out_free   = out_free;
    end

    // Control state: current slot, halt, table valid bits, scan and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= IDX_ONE;
            halt_reg      <= 1'b0;
            st_vld_reg    <= '0;
            ex_vld_reg    <= '0;
            lk_vld_reg    <= '0;
            st_rvld_reg   <= 1'b0;
            ex_rvld_reg   <= 1'b0;
            lk_rvld_reg   <= 1'b0;
            st_raddr_reg  <= '0;
            scan_left_reg <= '0;
            chk_vld_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.set_halt)
            begin
                halt_reg <= 1'b1;
            end
            if (ctl.sched_take)
            begin
                cur_reg <= chk_idx_reg;
            end
            if (ctl.st_we)
            begin
                st_vld_reg[st_waddr] <= 1'b1;
            end
            if (ctl.ex_we)
            begin
                ex_vld_reg[ex_waddr] <= 1'b1;
            end
            if (ctl.lk_we)
            begin
                lk_vld_reg[lk_waddr] <= 1'b1;
            end
            if (st_rd_en)
            begin
                st_rvld_reg  <= st_vld_reg[st_rd_addr];
                st_raddr_reg <= st_rd_addr;
            end
            if (ctl.probe)
            begin
                ex_rvld_reg <= ex_vld_reg[probe_addr];
                lk_rvld_reg <= lk_vld_reg[probe_addr];
            end

            // Scan counters.
            if (ctl.scan_start)
            begin
                scan_left_reg <= ctl.scan_alloc ? CW'(NUM_SLOTS - 1) : CW'(NUM_SLOTS);
                chk_vld_reg   <= 1'b0;
            end
            else if (scan_rd)
            begin
                scan_left_reg <= scan_left_reg - CW'(1);
                chk_vld_reg   <= 1'b1;
            end
            else
            begin
                chk_vld_reg <= 1'b0;
            end

            // Result register handshake.
            if (ctl.out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            op_reg    <= psm_op_t'(cmd);
            arg_reg   <= argument;
            rv_reg    <= 1'b0;
            rval_reg  <= '0;
            wkv_reg   <= 1'b0;
            wks_reg   <= '0;
            wkval_reg <= '0;
            idle_reg  <= 1'b0;
        end
        if (ctl.probe)
        begin
            tgt_reg  <= probe_addr;
            stat_reg <= ctl.probe_cur ? arg_reg : NEG_ONE;
        end
        if (ctl.ret_en)
        begin
            rv_reg <= 1'b1;
            unique case (ctl.ret_sel)
                RET_CUR:  rval_reg <= 32'(cur_reg);
                RET_NEG1: rval_reg <= NEG_ONE;
                RET_ZERO: rval_reg <= '0;
                RET_EXIT: rval_reg <= ex_val;
                RET_CHK:  rval_reg <= 32'(chk_idx_reg);
                default:  rval_reg <= '0;
            endcase
        end
        if (ctl.wake_load)
        begin
            wkv_reg   <= 1'b1;
            wks_reg   <= lk_idx;
            wkval_reg <= stat_reg;
        end
        if (ctl.set_idle)
        begin
            idle_reg <= 1'b1;
        end

        // Scan address walk.
        if (ctl.scan_start)
        begin
            scan_alloc_reg <= ctl.scan_alloc;
            scan_addr_reg  <= ctl.scan_alloc ? IDX_ONE : wrap_inc(cur_reg);
        end
        else if (scan_rd)
        begin
            chk_idx_reg   <= scan_addr_reg;
            chk_last_reg  <= (scan_left_reg == CW'(1));
            scan_addr_reg <= wrap_inc(scan_addr_reg);
        end

        // Result capture.
        if (ctl.out_load)
        begin
            o_rv_reg    <= rv_reg;
            o_rval_reg  <= rval_reg;
            o_wkv_reg   <= wkv_reg;
            o_wks_reg   <= 4'(wks_reg);
            o_wkval_reg <= wkval_reg;
            o_next_reg  <= 4'(cur_reg);
            o_idle_reg  <= idle_reg;
            o_halt_reg  <= halt_reg;
        end
    end

    assign res_valid     = res_valid_reg;
    assign return_valid  = o_rv_reg;
    assign return_value  = o_rval_reg;
    assign wake_valid    = o_wkv_reg;
    assign wake_slot     = o_wks_reg;
    assign wake_value    = o_wkval_reg;
    assign next_slot     = o_next_reg;
    assign none_runnable = o_idle_reg;
    assign halted        = o_halt_reg;

endmodule

### rtl/process_slot_manager.sv
// ============================================================================
// process_slot_manager
// Hardware thread-slot manager with a round-robin scheduler.
// ============================================================================
// One request carries a system call and its argument and yields exactly one
// result. Calls are handled one at a time. fork and newthread walk the slot
// state memory one slot per cycle. A scan stops at the first matching slot.
// The state memory has a single read port, shared by scans and probes.
// A new request is taken as soon as the previous result sits in the output
// register, even while that result is stalled. No clearing pass follows
// reset: per-slot valid bits supply the reset contents of the tables.
module process_slot_manager #(
    parameter int NUM_SLOTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [2:0]         cmd,
    input  logic signed [31:0] argument,
    output logic               res_valid,
    input  logic               res_stall,
    output logic               return_valid,
    output logic signed [31:0] return_value,
    output logic               wake_valid,
    output logic [3:0]         wake_slot,
    output logic signed [31:0] wake_value,
    output logic [3:0]         next_slot,
    output logic               none_runnable,
    output logic               halted
);

    import psm_pkg::*;

    psm_ctl_t ctl;
    psm_sts_t sts;

    // Call sequencer.
    psm_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Slot tables and result path.
    psm_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .cmd           (cmd),
        .argument      (argument),
        .res_stall     (res_stall),
        .res_valid     (res_valid),
        .return_valid  (return_valid),
        .return_value  (return_value),
        .wake_valid    (wake_valid),
        .wake_slot     (wake_slot),
        .wake_value    (wake_value),
        .next_slot     (next_slot),
        .none_runnable (none_runnable),
        .halted        (halted)
    );

endmodule

### rtl/psm_checker.sv
// ============================================================================
// psm_checker
// Port-level checks of the process slot manager, bound to the top level.
// ============================================================================
module psm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic               res_valid,
    input logic               res_stall,
    input logic               return_valid,
    input logic signed [31:0] return_value,
    input logic               wake_valid,
    input logic [3:0]         wake_slot,
    input logic signed [31:0] wake_value,
    input logic [3:0]         next_slot,
    input logic               none_runnable,
    input logic               halted
);

    logic seen_halt_reg;

    // Remembers that a halted result has been delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_halt_reg <= 1'b0;
        end
        else if (res_valid && !res_stall && halted)
        begin
            seen_halt_reg <= 1'b1;
        end
    end

    // A stalled result stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    // Once halted, every later result reports the halt.
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && seen_halt_reg |-> halted)
        else $error("halt flag cleared after a halt");

    // A halted result carries no return, no wake and no idle flag.
    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && halted |-> !return_valid && !wake_valid && !none_runnable)
        else $error("halted result has side effects");

    // Without a return, the return value reads zero.
    a_ret_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !return_valid |-> return_value == 32'sd0)
        else $error("return value without return");

    // Without a wake, the wake fields read zero.
    a_wake_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !wake_valid |-> wake_slot == 4'd0 && wake_value == 32'sd0)
        else $error("wake fields without wake");

endmodule

bind process_slot_manager psm_checker u_psm_checker (.*);
